// ===== hw/rtl/rdm_pkg.sv =====
package rdm_pkg;

    localparam int DAY_BITS_DEFAULT   = 24;
    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int CFG_INDEX_BITS     = 3;
    localparam int CFG_DATA_BITS      = 24;
    localparam int MONTH_BITS         = 18;
    localparam int MDAY_BITS          = 5;
    localparam int WDAY_BITS          = 3;
    localparam int MASK_BITS          = 7;
    localparam int IVL_BITS           = 16;
    localparam int LIMIT_BITS         = 16;
    localparam int REF_BITS           = 24;
    localparam int OUT_INDEX_BITS     = 16;
    localparam int DIVISOR_BITS       = IVL_BITS + 3;
    localparam int WEEK_DAYS          = 7;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [1:0] MODE_DAILY   = 2'd0;
    localparam logic [1:0] MODE_WEEKLY  = 2'd1;
    localparam logic [1:0] MODE_MONTHLY = 2'd2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MODE,
        REG_INTERVAL,
        REG_COUNT_LIMIT,
        REG_ANCHOR_REF,
        REG_WEEKDAY_MASK,
        REG_TARGET_MDAY,
        REG_LAST_DAY,
        REG_FIRST_DAY
    } reg_index_t;

    typedef struct packed {
        logic [1:0]            mode;
        logic [IVL_BITS-1:0]   interval;
        logic [LIMIT_BITS-1:0] count_limit;
        logic [REF_BITS-1:0]   anchor_ref;
        logic [MASK_BITS-1:0]  weekday_mask;
        logic [MDAY_BITS-1:0]  target_mday;
        logic [REF_BITS-1:0]   last_day;
        logic [REF_BITS-1:0]   first_day;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        mode:         MODE_DAILY,
        interval:     16'd1,
        count_limit:  16'd0,
        anchor_ref:   24'd0,
        weekday_mask: 7'd1,
        target_mday:  5'd1,
        last_day:     24'hFFFFFF,
        first_day:    24'd0
    };

    // classification of one day, made by the front part
    typedef struct packed {
        logic weekly;
        logic past_last;
        logic candidate;
        logic after_first;
    } flags_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_FINISH
    } back_state_t;

endpackage

// ===== hw/rtl/rdm_queue.sv =====
module rdm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rdm_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] fill_reg;

    assign full     = (fill_reg == CNT_BITS'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/rdm_front.sv =====
module rdm_front #(
    parameter int DAY_BITS = rdm_pkg::DAY_BITS_DEFAULT,
    parameter int NUM_BITS = rdm_pkg::DAY_BITS_DEFAULT
) (
    input  rdm_pkg::cfg_t                       cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [DAY_BITS-1:0]                 day_number,
    input  logic [rdm_pkg::MONTH_BITS-1:0]      month_index,
    input  logic [rdm_pkg::MDAY_BITS-1:0]       day_of_month,
    input  logic [rdm_pkg::WDAY_BITS-1:0]       day_of_week,
    input  logic                                q_full,
    output logic                                push,
    output rdm_pkg::flags_t                     flags,
    output logic [NUM_BITS-1:0]                 dividend,
    output logic [rdm_pkg::DIVISOR_BITS-1:0]    divisor
);

    logic [DAY_BITS-1:0]                anchor_d;
    logic [DAY_BITS-1:0]                last_d;
    logic [DAY_BITS-1:0]                first_d;
    logic [rdm_pkg::IVL_BITS-1:0]       ivl;
    logic [rdm_pkg::WDAY_BITS-1:0]      wd_offset;
    logic [DAY_BITS-1:0]                monday;
    logic [DAY_BITS-1:0]                day_diff;
    logic [DAY_BITS-1:0]                week_diff;
    logic [DAY_BITS-1:0]                early_gap;
    logic [rdm_pkg::MONTH_BITS-1:0]     month_diff;
    logic                               dow_ok;
    logic                               mask_hit;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    assign anchor_d = DAY_BITS'(cfg.anchor_ref);
    assign last_d   = DAY_BITS'(cfg.last_day);
    assign first_d  = DAY_BITS'(cfg.first_day);
    assign ivl      = (cfg.interval == '0) ? rdm_pkg::IVL_BITS'(1) : cfg.interval;

    assign wd_offset  = day_of_week - 1'b1;
    assign monday     = day_number - DAY_BITS'(wd_offset);
    assign day_diff   = day_number - anchor_d;
    assign week_diff  = monday - anchor_d;
    assign early_gap  = anchor_d - monday;
    assign month_diff = month_index - cfg.anchor_ref[rdm_pkg::MONTH_BITS-1:0];

    assign dow_ok = (day_of_week >= rdm_pkg::WDAY_BITS'(1))
                 && (day_of_week <= rdm_pkg::WDAY_BITS'(rdm_pkg::WEEK_DAYS))
                 && (day_number >= DAY_BITS'(wd_offset));
    assign mask_hit = dow_ok && cfg.weekday_mask[wd_offset];

    always_comb
    begin
        flags.weekly      = 1'b0;
        flags.past_last   = (day_number > last_d);
        flags.after_first = (day_number >= first_d);
        flags.candidate   = 1'b0;
        dividend          = '0;
        divisor           = rdm_pkg::DIVISOR_BITS'(ivl);
        case (cfg.mode)
            rdm_pkg::MODE_DAILY:
            begin
                flags.candidate = (day_number >= anchor_d);
                dividend        = NUM_BITS'(day_diff);
            end
            rdm_pkg::MODE_WEEKLY:
            begin
                // week index aligned iff offset mod (7 * interval) stays below 7
                flags.weekly = 1'b1;
                divisor      = {ivl, 3'b000} - rdm_pkg::DIVISOR_BITS'(ivl);
                if (monday >= anchor_d)
                begin
                    flags.candidate = mask_hit;
                    dividend        = NUM_BITS'(week_diff);
                end
                else if (early_gap < DAY_BITS'(rdm_pkg::WEEK_DAYS))
                begin
                    // partial week before the anchor counts as week zero
                    flags.candidate = mask_hit;
                end
            end
            rdm_pkg::MODE_MONTHLY:
            begin
                flags.candidate = (rdm_pkg::REF_BITS'(month_index) >= cfg.anchor_ref)
                               && (day_of_month == cfg.target_mday);
                dividend        = NUM_BITS'(month_diff);
            end
            default:
            begin
                flags.candidate = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/rdm_back.sv =====
module rdm_back #(
    parameter int NUM_BITS   = rdm_pkg::DAY_BITS_DEFAULT,
    parameter int COUNT_BITS = rdm_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_empty,
    output logic                                  pop,
    input  rdm_pkg::flags_t                       q_flags,
    input  logic [NUM_BITS-1:0]                   q_dividend,
    input  logic [rdm_pkg::DIVISOR_BITS-1:0]      q_divisor,
    input  logic [rdm_pkg::LIMIT_BITS-1:0]        count_limit,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  emit,
    output logic [rdm_pkg::OUT_INDEX_BITS-1:0]    occurrence_index,
    output logic                                  finished
);

    localparam int STEP_BITS = $clog2(NUM_BITS + 1);
    localparam int DB        = rdm_pkg::DIVISOR_BITS;
    localparam int CMP_BITS  = (COUNT_BITS + 1 > rdm_pkg::LIMIT_BITS) ?
                               COUNT_BITS + 1 : rdm_pkg::LIMIT_BITS;

    rdm_pkg::back_state_t       state_reg;
    rdm_pkg::back_state_t       state_next;
    rdm_pkg::flags_t            flags_reg;
    logic [NUM_BITS-1:0]        dvd_reg;
    logic [DB-1:0]              div_reg;
    logic [DB-1:0]              rem_reg;
    logic [STEP_BITS-1:0]       step_reg;
    logic [COUNT_BITS-1:0]      count_reg;
    logic                       stopped_reg;
    logic                       out_valid_reg;
    logic                       emit_reg;
    logic [rdm_pkg::OUT_INDEX_BITS-1:0] index_reg;
    logic                       finished_reg;

    logic [DB:0]                trial;
    logic [DB:0]                trial_sub;
    logic [DB-1:0]              rem_step;
    logic                       aligned;
    logic [COUNT_BITS:0]        count_inc;
    logic                       over_cap;
    logic                       need_div;
    logic                       slot_free;
    logic                       load_out;
    logic [COUNT_BITS-1:0]      count_after;
    logic                       stop_after;
    logic                       emit_now;

    // one restoring remainder step per cycle
    assign trial     = {rem_reg, dvd_reg[NUM_BITS-1]};
    assign trial_sub = trial - {1'b0, div_reg};
    assign rem_step  = (trial >= {1'b0, div_reg}) ? trial_sub[DB-1:0] : trial[DB-1:0];

    assign aligned   = flags_reg.weekly ? (rem_reg < DB'(rdm_pkg::WEEK_DAYS)) : (rem_reg == '0);
    assign count_inc = {1'b0, count_reg} + 1'b1;
    assign over_cap  = (count_limit != '0) && (CMP_BITS'(count_inc) > CMP_BITS'(count_limit));
    assign need_div  = q_flags.candidate && !q_flags.past_last && !stopped_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        count_after = count_reg;
        stop_after  = stopped_reg;
        emit_now    = 1'b0;
        if (!stopped_reg)
        begin
            if (flags_reg.past_last)
            begin
                stop_after = 1'b1;
            end
            else if (flags_reg.candidate && aligned)
            begin
                if (over_cap)
                begin
                    stop_after = 1'b1;
                end
                else
                begin
                    count_after = count_inc[COUNT_BITS] ? '1 : count_inc[COUNT_BITS-1:0];
                    emit_now    = flags_reg.after_first;
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            rdm_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    state_next = need_div ? rdm_pkg::BK_DIVIDE : rdm_pkg::BK_FINISH;
                end
            end
            rdm_pkg::BK_DIVIDE:
            begin
                if (step_reg == STEP_BITS'(NUM_BITS - 1))
                begin
                    state_next = rdm_pkg::BK_FINISH;
                end
            end
            rdm_pkg::BK_FINISH:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = rdm_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = rdm_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rdm_pkg::BK_IDLE;
            count_reg     <= '0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                count_reg     <= count_after;
                stopped_reg   <= stop_after;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            flags_reg <= q_flags;
            dvd_reg   <= q_dividend;
            div_reg   <= q_divisor;
            rem_reg   <= '0;
            step_reg  <= '0;
        end
        else if (state_reg == rdm_pkg::BK_DIVIDE)
        begin
            rem_reg  <= rem_step;
            dvd_reg  <= {dvd_reg[NUM_BITS-2:0], 1'b0};
            step_reg <= step_reg + 1'b1;
        end
        if (load_out)
        begin
            emit_reg     <= emit_now;
            index_reg    <= rdm_pkg::OUT_INDEX_BITS'(count_after);
            finished_reg <= stop_after;
        end
    end

    assign out_valid        = out_valid_reg;
    assign emit             = emit_reg;
    assign occurrence_index = index_reg;
    assign finished         = finished_reg;

endmodule

// ===== hw/rtl/recurrence_day_matcher_top.sv =====
// channel  direction  handshake              payload
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
// in       in         in_valid / in_ready    day_number, month_index, day_of_month, day_of_week
// out      out        out_valid / out_ready  emit, occurrence_index, finished
//
// a day that can match passes the back end through IDLE, DIVIDE and FINISH, bounded by the
// bit-serial max(DAY_BITS, 18)-bit remainder against the interval; other days skip DIVIDE
// a two-entry queue lets requests enter while the back end divides or the result waits
// reset clears configuration to defaults, the occurrence count and the stop flag
// cfg_ready is always high; write configuration only while the block is idle
module recurrence_day_matcher_top #(
    parameter int DAY_BITS   = rdm_pkg::DAY_BITS_DEFAULT,
    parameter int COUNT_BITS = rdm_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rdm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [rdm_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [DAY_BITS-1:0]                   day_number,
    input  logic [rdm_pkg::MONTH_BITS-1:0]        month_index,
    input  logic [rdm_pkg::MDAY_BITS-1:0]         day_of_month,
    input  logic [rdm_pkg::WDAY_BITS-1:0]         day_of_week,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  emit,
    output logic [rdm_pkg::OUT_INDEX_BITS-1:0]    occurrence_index,
    output logic                                  finished
);

    localparam int NUM_BITS   = (DAY_BITS > rdm_pkg::MONTH_BITS) ? DAY_BITS : rdm_pkg::MONTH_BITS;
    localparam int FLAG_BITS  = $bits(rdm_pkg::flags_t);
    localparam int ENTRY_BITS = FLAG_BITS + NUM_BITS + rdm_pkg::DIVISOR_BITS;

    rdm_pkg::cfg_t                        cfg_reg;
    rdm_pkg::flags_t                      f_flags;
    logic [NUM_BITS-1:0]                  f_dividend;
    logic [rdm_pkg::DIVISOR_BITS-1:0]     f_divisor;
    logic                                 q_push;
    logic                                 q_pop;
    logic                                 q_full;
    logic                                 q_empty;
    logic [ENTRY_BITS-1:0]                q_out;
    rdm_pkg::flags_t                      b_flags;
    logic [NUM_BITS-1:0]                  b_dividend;
    logic [rdm_pkg::DIVISOR_BITS-1:0]     b_divisor;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= rdm_pkg::CFG_RESET;
        end
        else if (cfg_valid)
        begin
            case (rdm_pkg::reg_index_t'(cfg_index))
                rdm_pkg::REG_MODE:         cfg_reg.mode         <= cfg_data[1:0];
                rdm_pkg::REG_INTERVAL:     cfg_reg.interval     <= cfg_data[15:0];
                rdm_pkg::REG_COUNT_LIMIT:  cfg_reg.count_limit  <= cfg_data[15:0];
                rdm_pkg::REG_ANCHOR_REF:   cfg_reg.anchor_ref   <= cfg_data;
                rdm_pkg::REG_WEEKDAY_MASK: cfg_reg.weekday_mask <= cfg_data[6:0];
                rdm_pkg::REG_TARGET_MDAY:  cfg_reg.target_mday  <= cfg_data[4:0];
                rdm_pkg::REG_LAST_DAY:     cfg_reg.last_day     <= cfg_data;
                rdm_pkg::REG_FIRST_DAY:    cfg_reg.first_day    <= cfg_data;
                default:                   cfg_reg              <= cfg_reg;
            endcase
        end
    end

    rdm_front #(
        .DAY_BITS (DAY_BITS),
        .NUM_BITS (NUM_BITS)
    ) u_front (
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .day_number   (day_number),
        .month_index  (month_index),
        .day_of_month (day_of_month),
        .day_of_week  (day_of_week),
        .q_full       (q_full),
        .push         (q_push),
        .flags        (f_flags),
        .dividend     (f_dividend),
        .divisor      (f_divisor)
    );

    rdm_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (rdm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_flags, f_dividend, f_divisor}),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign {b_flags, b_dividend, b_divisor} = q_out;

    rdm_back #(
        .NUM_BITS   (NUM_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .pop              (q_pop),
        .q_flags          (b_flags),
        .q_dividend       (b_dividend),
        .q_divisor        (b_divisor),
        .count_limit      (cfg_reg.count_limit),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .emit             (emit),
        .occurrence_index (occurrence_index),
        .finished         (finished)
    );

endmodule
